// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Depends on nothing; checks compile away when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset.
`define TCEE_ASSERT(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
	else $error("%m: check failed");
// Antecedent implies consequent in the next cycle.
`define TCEE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("%m: check failed");
`else
`define TCEE_ASSERT(lbl, clk, rst_n, cond)
`define TCEE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/tcee_pkg.sv =====
// Shared types, constants and helpers of the text console escape engine.
// Depends on nothing.
package tcee_pkg;
	localparam int COLUMNS    = 80;
	localparam int ROW_COUNT  = 25;
	localparam int CELL_COUNT = COLUMNS * ROW_COUNT;
	localparam int CELL_W     = 11;
	localparam int COL_W      = 7;
	localparam int ROW_W      = 5;
	localparam int SCROLL_CELLS = COLUMNS * (ROW_COUNT - 1);
	localparam int TAB_SHIFT  = 3;

	localparam logic [7:0] DEFAULT_COLOR_RST = 8'd7;
	localparam logic [7:0] CLEAR_ATTR_RST    = 8'd2;
	localparam logic [7:0] ATTR_RED   = 8'd4;
	localparam logic [7:0] ATTR_GREEN = 8'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_J     = 8'h4A;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_M     = 8'h6D;

	localparam logic [6:0] CODE_CLEAR = 7'd2;
	localparam logic [6:0] CODE_RED   = 7'd31;
	localparam logic [6:0] CODE_GREEN = 7'd32;
	localparam logic [6:0] CODE_WHITE = 7'd37;
	localparam logic [6:0] CODE_DFLT  = 7'd39;

	localparam logic CFG_DEFAULT_COLOR = 1'b0;
	localparam logic CFG_CLEAR_ATTR    = 1'b1;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ESC     = 3'd1,
		PH_BRACKET = 3'd2,
		PH_N1      = 3'd3,
		PH_N2      = 3'd4,
		PH_SEMI    = 3'd5,
		PH_M1      = 3'd6,
		PH_M2      = 3'd7
	} esc_phase_t;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  data_byte;
		logic [10:0] cell_index;
	} tcee_in_t;

	typedef struct packed {
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [10:0] cursor_offset;
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
		logic        in_escape;
	} tcee_out_t;

	// controller -> datapath
	typedef struct packed {
		logic ld_in;
		logic exec;
		logic rd_cell;
		logic clr_step;
		logic init;
		logic scr_step;
		logic fill_step;
		logic cnt_zero;
		logic cnt_fill;
		logic cnt_inc;
		logic cap_out;
	} tcee_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_clear;
		logic need_scroll;
		logic cnt_last;
		logic scr_last;
	} tcee_sts_t;

	function automatic logic [CELL_W-1:0] cell_addr(logic [ROW_W-1:0] y, logic [COL_W-1:0] x);
		cell_addr = CELL_W'(y * COLUMNS) + CELL_W'(x);
	endfunction
endpackage

// ===== rtl/text_console_escape_engine.sv =====
// Top level of the text console escape engine: sequencer plus datapath.
// Depends on tcee_pkg, tcee_ctrl, tcee_dp and assert_macros.svh.

// Text console, 80x25 cells of char and attribute, fed one beat at a time.
// A byte beat passes accept, execute and hand-off on its way to a result; a
// cell read passes accept, RAM read and hand-off. A byte that clears the
// screen adds a sweep of the one-write, one-read RAM with one write per cell.
// A byte that scrolls adds a copy sweep (one cell read and written back per
// cycle), a drain state and a fill of the bottom row. After reset a clearing
// pass fills the screen with char 0 and attribute 2; in_stall stays high
// during it. The next beat is taken while the previous result still waits on
// out_stall.
module text_console_escape_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tcee_pkg::tcee_in_t in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output tcee_pkg::tcee_out_t out_item,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data
);
	import tcee_pkg::*;
	`include "assert_macros.svh"

	tcee_cmd_t cmd;
	tcee_sts_t sts;
	logic      cur_in_range;
	logic      offset_ok;

	// sequencer owns the sequencing states and all handshakes
	tcee_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_cmd    (in_item.cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// cursor, parser, screen memory and result register
	tcee_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_item  (out_item)
	);

	assign cur_in_range = (out_item.cursor_col < 7'(COLUMNS)) &&
	                      (out_item.cursor_row < 5'(ROW_COUNT));
	assign offset_ok    = (out_item.cursor_offset ==
	                       cell_addr(out_item.cursor_row, out_item.cursor_col));

	// an accepted beat always occupies the engine for at least the next cycle
	`TCEE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// cursor stays on screen
	`TCEE_ASSERT(a_cursor_range, clk, arst_n, !out_valid || cur_in_range)
	// offset agrees with row and column
	`TCEE_ASSERT(a_offset_match, clk, arst_n, !out_valid || offset_ok)
endmodule

// ===== rtl/tcee_ram.sv =====
// Generic one-write, one-read RAM with registered read data.
// Depends on nothing.
module tcee_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = $clog2(DEPTH),
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/tcee_ctrl.sv =====
// Sequencer of the console engine: item intake, cell sweeps, result hand-off.
// Depends on tcee_pkg.
module tcee_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_cmd,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  tcee_pkg::tcee_sts_t sts,
	output tcee_pkg::tcee_cmd_t cmd
);
	import tcee_pkg::*;

	typedef enum logic [8:0] {
		S_INIT   = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_READ   = 9'b000000100,
		S_EXEC   = 9'b000001000,
		S_CLEAR  = 9'b000010000,
		S_SCROLL = 9'b000100000,
		S_DRAIN  = 9'b001000000,
		S_FILL   = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.clr_step = 1'b1;
				cmd.init     = 1'b1;
				cmd.cnt_inc  = 1'b1;
				if (sts.cnt_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = (in_cmd == CMD_READ) ? S_READ : S_EXEC;
				end
			end
			S_READ: begin
				cmd.rd_cell = 1'b1;
				state_d     = S_DONE;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.need_clear) begin
					cmd.cnt_zero = 1'b1;
					state_d      = S_CLEAR;
				end else if (sts.need_scroll) begin
					cmd.cnt_zero = 1'b1;
					state_d      = S_SCROLL;
				end else begin
					state_d = S_DONE;
				end
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				cmd.cnt_inc  = 1'b1;
				if (sts.cnt_last) state_d = S_DONE;
			end
			S_SCROLL: begin
				cmd.scr_step = 1'b1;
				cmd.cnt_inc  = 1'b1;
				if (sts.scr_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				cmd.cnt_fill = 1'b1;
				state_d      = S_FILL;
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
				cmd.cnt_inc   = 1'b1;
				if (sts.cnt_last) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.cap_out = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.cap_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ===== rtl/tcee_dp.sv =====
// Datapath: cursor, parser, color and config registers, screen RAM, result register.
// Depends on tcee_pkg and tcee_ram.
module tcee_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  tcee_pkg::tcee_in_t  in_item,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data,
	input  tcee_pkg::tcee_cmd_t cmd,
	output tcee_pkg::tcee_sts_t sts,
	output tcee_pkg::tcee_out_t out_item
);
	import tcee_pkg::*;

	tcee_in_t         in_q;
	tcee_out_t        out_q;
	logic [COL_W-1:0] x_q, n_x;
	logic [ROW_W-1:0] y_q, n_y;
	logic [7:0]       col_q, n_col, dflt_q, clra_q;
	esc_phase_t       ph_q, n_ph;
	logic [6:0]       fn_q, sn_q, n_fn, n_sn;
	logic [CELL_W-1:0] cnt_q;
	logic             pend_s1;
	logic [CELL_W-1:0] addr_s1;

	// byte decode
	logic [7:0]       b;
	logic             digit, consumed, do_clr, do_scr, wr;
	logic [3:0]       d;
	logic [COL_W-1:0] wx;
	logic [7:0]       wch;
	logic [7:0]       x_adv;
	logic [4:0]       tab_hi;
	logic [6:0]       row_v, col_v;

	// RAM
	logic              we, re;
	logic [CELL_W-1:0] waddr, raddr;
	logic [15:0]       wdata, rdata;

	assign b      = in_q.data_byte;
	assign digit  = (b >= 8'h30) && (b <= 8'h39);
	assign d      = b[3:0];
	assign tab_hi = {1'b0, x_q[COL_W-1:TAB_SHIFT]} + 5'd1;
	assign row_v  = (fn_q == 7'd0) ? 7'd1 : fn_q;
	assign col_v  = (sn_q == 7'd0) ? 7'd1 : sn_q;

	always_comb begin
		n_x      = x_q;
		n_y      = y_q;
		n_col    = col_q;
		n_ph     = ph_q;
		n_fn     = fn_q;
		n_sn     = sn_q;
		consumed = 1'b0;
		do_clr   = 1'b0;
		do_scr   = 1'b0;
		wr       = 1'b0;
		wx       = x_q;
		wch      = b;
		x_adv    = {1'b0, x_q};
		case (ph_q)
			PH_ESC: begin
				if (b == CH_LBRK) begin
					n_ph = PH_BRACKET; consumed = 1'b1;
				end
			end
			PH_BRACKET: begin
				if (digit) begin
					n_fn = {3'b0, d}; n_ph = PH_N1; consumed = 1'b1;
				end
			end
			PH_N1, PH_N2: begin
				if (digit && ph_q == PH_N1) begin
					n_fn = 7'(fn_q * 7'd10 + {3'b0, d});
					n_ph = PH_N2; consumed = 1'b1;
				end else if (b == CH_J) begin
					n_ph = PH_IDLE; consumed = 1'b1;
					if (fn_q == CODE_CLEAR) begin
						do_clr = 1'b1; n_x = '0; n_y = '0;
					end
				end else if (b == CH_M) begin
					n_ph = PH_IDLE; consumed = 1'b1;
					if (fn_q == CODE_RED) n_col = ATTR_RED;
					else if (fn_q == CODE_GREEN) n_col = ATTR_GREEN;
					else if (fn_q == CODE_WHITE || fn_q == CODE_DFLT) n_col = dflt_q;
				end else if (b == CH_SEMI) begin
					n_ph = PH_SEMI; consumed = 1'b1;
				end
			end
			PH_SEMI: begin
				if (digit) begin
					n_sn = {3'b0, d}; n_ph = PH_M1; consumed = 1'b1;
				end
			end
			PH_M1, PH_M2: begin
				if (digit && ph_q == PH_M1) begin
					n_sn = 7'(sn_q * 7'd10 + {3'b0, d});
					n_ph = PH_M2; consumed = 1'b1;
				end else if (b == CH_H || b == CH_F) begin
					n_ph = PH_IDLE; consumed = 1'b1;
					if (col_v <= 7'(COLUMNS) && row_v <= 7'(ROW_COUNT)) begin
						n_x = COL_W'(col_v - 7'd1);
						n_y = ROW_W'(row_v - 7'd1);
					end
				end
			end
			default: ;
		endcase
		if (!consumed) begin
			n_ph = PH_IDLE;
			if (b == CH_ESC) begin
				n_ph = PH_ESC;
			end else if (b != CH_NUL) begin
				if (b == CH_TAB) begin
					x_adv = {tab_hi, 3'b000};
				end else if (b == CH_CR) begin
					x_adv = '0;
				end else if (b == CH_LF) begin
					x_adv = {1'b0, x_q};
				end else if (b == CH_BS) begin
					if (x_q != '0) begin
						x_adv = {1'b0, x_q} - 8'd1;
						wr    = 1'b1;
						wx    = x_q - COL_W'(1);
						wch   = CH_SPACE;
					end
				end else begin
					wr    = 1'b1;
					x_adv = {1'b0, x_q} + 8'd1;
				end
				if (x_adv >= 8'(COLUMNS) || b == CH_LF) begin
					n_x = '0;
					if (y_q < ROW_W'(ROW_COUNT - 1)) n_y = y_q + ROW_W'(1);
					else do_scr = 1'b1;
				end else begin
					n_x = x_adv[COL_W-1:0];
				end
			end
		end
	end

	assign sts.need_clear  = do_clr;
	assign sts.need_scroll = do_scr;
	assign sts.cnt_last    = (cnt_q == CELL_W'(CELL_COUNT - 1));
	assign sts.scr_last    = (cnt_q == CELL_W'(SCROLL_CELLS - 1));

	// write port priority: byte write, scroll write-back, clear, bottom fill
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = {col_q, CH_SPACE};
		if (cmd.exec && wr) begin
			we    = 1'b1;
			waddr = cell_addr(y_q, wx);
			wdata = {col_q, wch};
		end else if (pend_s1) begin
			we    = 1'b1;
			waddr = addr_s1;
			wdata = rdata;
		end else if (cmd.clr_step) begin
			we    = 1'b1;
			wdata = {(cmd.init ? CLEAR_ATTR_RST : clra_q), CH_NUL};
		end else if (cmd.fill_step) begin
			we    = 1'b1;
		end
	end

	assign re    = cmd.rd_cell || cmd.scr_step;
	assign raddr = cmd.rd_cell ? CELL_W'(in_q.cell_index) : cnt_q + CELL_W'(COLUMNS);

	tcee_ram #(.DEPTH(CELL_COUNT), .AW(CELL_W), .DW(16)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			col_q   <= DEFAULT_COLOR_RST;
			dflt_q  <= DEFAULT_COLOR_RST;
			clra_q  <= CLEAR_ATTR_RST;
			ph_q    <= PH_IDLE;
			fn_q    <= '0;
			sn_q    <= '0;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == CFG_DEFAULT_COLOR) dflt_q <= cfg_data;
			if (cfg_we && cfg_index == CFG_CLEAR_ATTR)    clra_q <= cfg_data;
			if (cmd.exec) begin
				x_q   <= n_x;
				y_q   <= n_y;
				col_q <= n_col;
				ph_q  <= n_ph;
				fn_q  <= n_fn;
				sn_q  <= n_sn;
			end
			if (cmd.cnt_zero) cnt_q <= '0;
			else if (cmd.cnt_fill) cnt_q <= CELL_W'(SCROLL_CELLS);
			else if (cmd.cnt_inc) cnt_q <= cnt_q + CELL_W'(1);
			pend_s1 <= cmd.scr_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) in_q <= in_item;
		addr_s1 <= cnt_q;
		if (cmd.cap_out) begin
			out_q.cursor_col    <= x_q;
			out_q.cursor_row    <= y_q;
			out_q.cursor_offset <= cell_addr(y_q, x_q);
			out_q.in_escape     <= (ph_q != PH_IDLE);
			if (in_q.cmd == CMD_READ && in_q.cell_index < 11'(CELL_COUNT)) begin
				out_q.cell_char <= rdata[7:0];
				out_q.cell_attr <= rdata[15:8];
			end else begin
				out_q.cell_char <= '0;
				out_q.cell_attr <= '0;
			end
		end
	end

	assign out_item = out_q;
endmodule

// ===== tb/text_console_escape_engine_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the text console escape engine: a directed table and
// random console traffic, checked against a behavioral screen model. Uses tcee_pkg.
module text_console_escape_engine_test;
	import tcee_pkg::*;

	localparam int IDLE_LIMIT = 12000; // clear or scroll sweep plus a stall burst, several times
	localparam int SETTLE_CYC = 10;
	localparam int PHASE_BEATS = 250;

	typedef struct {
		tcee_in_t  it;
		bit        typed;
		tcee_out_t want;
	} beat_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	tcee_in_t  in_item = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	tcee_out_t out_item;
	logic      cfg_we = 1'b0;
	logic      cfg_index = CFG_DEFAULT_COLOR;
	logic [7:0] cfg_data = '0;

	text_console_escape_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// ---- screen model: cells, cursor, color, escape parser, registers ----
	logic [15:0] scr [CELL_COUNT];
	int          cx, cy;
	logic [7:0]  color, dflt_color, clr_attr;
	esc_phase_t  ph;
	int          num_a, num_b;

	beat_row_t   plan[$];
	tcee_out_t   want_q[$];
	int          taken, checked, errors, reads, scrolls;
	bit          calm;

	function automatic void paint(int x, int y, logic [7:0] ch);
		if (y * COLUMNS + x < CELL_COUNT)
			scr[y * COLUMNS + x] = {color, ch};
	endfunction

	function automatic void wipe();
		for (int i = 0; i < CELL_COUNT; i++)
			scr[i] = {clr_attr, 8'h00};
		cx = 0;
		cy = 0;
	endfunction

	function automatic void line_feed();
		cx = 0;
		if (cy < ROW_COUNT - 1) begin
			cy++;
			return;
		end
		scrolls++;
		for (int i = 0; i < SCROLL_CELLS; i++)
			scr[i] = scr[i + COLUMNS];
		for (int i = 0; i < COLUMNS; i++)
			paint(i, ROW_COUNT - 1, CH_SPACE);
	endfunction

	function automatic void plain_byte(logic [7:0] b);
		if (b == CH_ESC) begin
			ph = PH_ESC;
			return;
		end
		if (b == CH_NUL)
			return;
		if (b == CH_TAB)
			cx = (cx / 8 + 1) * 8;
		else if (b == CH_CR)
			cx = 0;
		else if (b == CH_BS) begin
			if (cx > 0) begin
				cx--;
				paint(cx, cy, CH_SPACE);
			end
		end else if (b != CH_LF) begin
			paint(cx, cy, b);
			cx++;
		end
		if (cx >= COLUMNS || b == CH_LF)
			line_feed();
	endfunction

	// True when the parser swallows the byte; otherwise the sequence is dropped.
	function automatic bit parse_esc(logic [7:0] b);
		bit dig;
		int d;
		int r, c;
		dig = (b >= 8'h30 && b <= 8'h39);
		d = int'(b) - 8'h30;
		case (ph)
			PH_ESC: begin
				if (b == CH_LBRK) begin ph = PH_BRACKET; return 1; end
			end
			PH_BRACKET: begin
				if (dig) begin num_a = d; ph = PH_N1; return 1; end
			end
			PH_N1, PH_N2: begin
				if (dig && ph == PH_N1) begin
					num_a = (num_a * 10 + d) & 8'h7F;
					ph = PH_N2;
					return 1;
				end
				if (b == CH_J) begin
					ph = PH_IDLE;
					if (num_a == CODE_CLEAR) wipe();
					return 1;
				end
				if (b == CH_M) begin
					ph = PH_IDLE;
					if (num_a == CODE_RED) color = ATTR_RED;
					else if (num_a == CODE_GREEN) color = ATTR_GREEN;
					else if (num_a == CODE_WHITE || num_a == CODE_DFLT) color = dflt_color;
					return 1;
				end
				if (b == CH_SEMI) begin ph = PH_SEMI; return 1; end
			end
			PH_SEMI: begin
				if (dig) begin num_b = d; ph = PH_M1; return 1; end
			end
			PH_M1, PH_M2: begin
				if (dig && ph == PH_M1) begin
					num_b = (num_b * 10 + d) & 8'h7F;
					ph = PH_M2;
					return 1;
				end
				if (b == CH_H || b == CH_F) begin
					ph = PH_IDLE;
					r = num_a == 0 ? 1 : num_a;
					c = num_b == 0 ? 1 : num_b;
					if (c <= COLUMNS && r <= ROW_COUNT) begin
						cx = c - 1;
						cy = r - 1;
					end
					return 1;
				end
			end
			default: ;
		endcase
		ph = PH_IDLE;
		return 0;
	endfunction

	function automatic tcee_out_t console_step(tcee_in_t it);
		tcee_out_t r;
		r = '0;
		if (it.cmd == CMD_READ) begin
			reads++;
			if (it.cell_index < CELL_COUNT)
				{r.cell_attr, r.cell_char} = scr[it.cell_index];
		end else if (ph == PH_IDLE || !parse_esc(it.data_byte))
			plain_byte(it.data_byte);
		r.cursor_col    = COL_W'(cx);
		r.cursor_row    = ROW_W'(cy);
		r.cursor_offset = CELL_W'(cy * COLUMNS + cx);
		r.in_escape     = (ph != PH_IDLE);
		return r;
	endfunction

	// ---- stimulus table ----
	function automatic tcee_out_t at_cursor(int col, int row, int ch, int at, bit esc);
		tcee_out_t r;
		r.cursor_col    = COL_W'(col);
		r.cursor_row    = ROW_W'(row);
		r.cursor_offset = CELL_W'(row * COLUMNS + col);
		r.cell_char     = 8'(ch);
		r.cell_attr     = 8'(at);
		r.in_escape     = esc;
		return r;
	endfunction

	function automatic void add_beat(logic c, logic [7:0] b, logic [10:0] idx,
			bit typed = 0, tcee_out_t w = '0);
		beat_row_t row;
		row.it.cmd = c;
		row.it.data_byte = b;
		row.it.cell_index = idx;
		row.typed = typed;
		row.want = w;
		plan.push_back(row);
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_beat(CMD_BYTE, s[i], 11'($urandom_range(0, 2047)));
	endfunction

	function automatic void add_read();
		add_beat(CMD_READ, 8'($urandom_range(0, 255)),
			$urandom_range(0, 9) == 0 ? 11'($urandom_range(CELL_COUNT, 2047))
			                          : 11'($urandom_range(0, CELL_COUNT - 1)));
	endfunction

	// One well-formed escape sequence with random content.
	function automatic string esc_seq();
		int k;
		int codes[4] = '{31, 32, 37, 39};
		k = $urandom_range(0, 19);
		if (k == 0)
			return "\033[2J";
		if (k < 3)
			return $sformatf("\033[%0dJ", $urandom_range(0, 99));
		if (k < 9)
			return $sformatf("\033[%0dm", $urandom_range(0, 3) == 0 ?
				$urandom_range(0, 99) : codes[$urandom_range(0, 3)]);
		return $sformatf("\033[%0d;%0d%s", $urandom_range(0, 30), $urandom_range(0, 90),
			$urandom_range(0, 1) ? "H" : "f");
	endfunction

	function automatic void add_phrase();
		int k, n;
		string s;
		k = $urandom_range(0, 99);
		if (k < 45) begin
			// text run, mostly printable, some control bytes
			n = $urandom_range(1, 10);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 11))
					0: add_beat(CMD_BYTE, CH_LF, 11'($urandom_range(0, 2047)));
					1: add_beat(CMD_BYTE, CH_TAB, 11'($urandom_range(0, 2047)));
					2: add_beat(CMD_BYTE, CH_BS, 11'($urandom_range(0, 2047)));
					3: add_beat(CMD_BYTE, CH_CR, 11'($urandom_range(0, 2047)));
					default: add_beat(CMD_BYTE, 8'($urandom_range(32, 255)),
						11'($urandom_range(0, 2047)));
				endcase
			end
		end else if (k < 70)
			add_text(esc_seq());
		else if (k < 80)
			add_read();
		else if (k < 88)
			add_beat(CMD_BYTE, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
		else begin
			// sequence cut short, then a stray byte or a digit, maybe a read inside
			s = esc_seq();
			n = $urandom_range(1, s.len() - 1);
			for (int i = 0; i < n; i++) begin
				add_beat(CMD_BYTE, s[i], 11'($urandom_range(0, 2047)));
				if ($urandom_range(0, 3) == 0)
					add_read();
			end
			add_beat(CMD_BYTE, $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(8'h30, 8'h39)), 11'($urandom_range(0, 2047)));
		end
	endfunction

	// ---- monitor: predict on input beats, check output beats, config shadow ----
	always @(posedge clk) begin
		tcee_out_t p, w;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == CFG_DEFAULT_COLOR)
					dflt_color = cfg_data;
				else
					clr_attr = cfg_data;
			end
			if (in_valid && !in_stall) begin
				p = console_step(in_item);
				want_q.push_back(plan[taken].typed ? plan[taken].want : p);
				taken++;
			end
			if (out_valid && !out_stall) begin
				if (want_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result beat: %p", out_item);
				end else begin
					w = want_q.pop_front();
					checked++;
					if (out_item.cursor_col !== w.cursor_col ||
					    out_item.cursor_row !== w.cursor_row ||
					    out_item.cursor_offset !== w.cursor_offset ||
					    out_item.cell_char !== w.cell_char ||
					    out_item.cell_attr !== w.cell_attr ||
					    out_item.in_escape !== w.in_escape) begin
						errors++;
						if (errors <= 10)
							$display("result %0d mismatch: expected %p got %p",
								checked, w, out_item);
					end
				end
			end
		end
	end

	// Receiver stalls in random bursts; none once calm is set.
	int stall_left = 0;
	always @(posedge clk) begin
		if (calm)
			out_stall <= 1'b0;
		else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 11) - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	// Watchdog on cycles with no beat on either channel.
	int quiet_cyc = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cyc = 0;
		else if (++quiet_cyc >= IDLE_LIMIT) begin
			$display("[text_console_escape_engine] ERROR");
			$finish;
		end
	end

	// Leaves in_valid as it is after the last beat; drain() drops it.
	task automatic drive_from(int first);
		for (int i = first; i < plan.size(); i++) begin
			if (!calm && $urandom_range(0, 5) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			in_item  <= plan[i].it;
			in_valid <= 1'b1;
			@(posedge clk);
			while (in_stall) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (want_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Leaves cfg_we high; the caller drops it after the last write.
	task automatic write_reg(logic idx, logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	initial begin
		int first;
		logic [7:0] dc, ca;
		dflt_color = DEFAULT_COLOR_RST;
		clr_attr   = CLEAR_ATTR_RST;
		wipe();
		color = dflt_color;
		ph = PH_IDLE;
		num_a = 0;
		num_b = 0;

		// Directed: reset screen, read extremes, controls, null, abandoned escape,
		// red color, move to the far corner and wrap into a scroll.
		add_beat(CMD_READ, 8'h00, 11'd0, 1, at_cursor(0, 0, 0, 2, 0));
		add_beat(CMD_READ, 8'hFF, 11'd2047, 1, at_cursor(0, 0, 0, 0, 0));
		add_beat(CMD_BYTE, 8'hFF, 11'd0, 1, at_cursor(1, 0, 0, 0, 0));
		add_beat(CMD_READ, 8'h00, 11'd0, 1, at_cursor(1, 0, 8'hFF, 7, 0));
		add_beat(CMD_BYTE, CH_NUL, 11'd2047, 1, at_cursor(1, 0, 0, 0, 0));
		add_beat(CMD_BYTE, CH_TAB, 11'd0, 1, at_cursor(8, 0, 0, 0, 0));
		add_beat(CMD_BYTE, CH_BS, 11'd0, 1, at_cursor(7, 0, 0, 0, 0));
		add_beat(CMD_BYTE, CH_LF, 11'd0, 1, at_cursor(0, 1, 0, 0, 0));
		add_beat(CMD_BYTE, CH_ESC, 11'd0, 1, at_cursor(0, 1, 0, 0, 1));
		add_beat(CMD_BYTE, CH_NUL, 11'd0, 1, at_cursor(0, 1, 0, 0, 0));
		add_text("\033[31mA\033[25;80HZ");

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		drive_from(0);

		for (int p = 0; p < 4; p++) begin
			if (p > 0) begin
				// sender holds off until every result is back, then reprograms
				drain();
				dc = p == 1 ? 8'h00 : p == 2 ? 8'hFF : 8'($urandom_range(0, 255));
				ca = p == 1 ? 8'h00 : p == 2 ? 8'hFF : 8'($urandom_range(0, 255));
				write_reg(CFG_DEFAULT_COLOR, dc);
				write_reg(CFG_CLEAR_ATTR, ca);
				cfg_we <= 1'b0;
			end
			calm = (p == 3);
			first = plan.size();
			while (plan.size() - first < PHASE_BEATS)
				add_phrase();
			drive_from(first);
		end

		drain();
		$display("%0d beats driven, %0d results checked, %0d cell reads, %0d scrolls",
			taken, checked, reads, scrolls);
		$display("four register settings including all-zero and all-one values");
		if (errors == 0 && want_q.size() == 0)
			$display("[text_console_escape_engine] OK");
		else
			$display("[text_console_escape_engine] ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tcee_pkg.sv
rtl/tcee_ram.sv
rtl/tcee_ctrl.sv
rtl/tcee_dp.sv
rtl/text_console_escape_engine.sv
tb/text_console_escape_engine_test.sv
